[rtl/qsfd_pkg.sv]
`timescale 1ns / 1ps
// qsfd_pkg: shared types, codes and the escape digit function for the
// query string field decoder; no dependencies

package qsfd_pkg;

  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_AMP   = 8'h26;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_UPA   = 8'h41;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CASE_MASK  = 8'hDF;
  localparam logic [7:0] LETTER_OFS = 8'd10;

  typedef enum logic {
    IK_BYTE = 1'b0,
    IK_END  = 1'b1
  } in_kind_t;

  typedef enum logic {
    RK_DATA = 1'b0,
    RK_END  = 1'b1
  } res_kind_t;

  typedef enum logic [1:0] {
    PH_COPY = 2'd0,
    PH_PCT  = 2'd1,
    PH_HIGH = 2'd2,
    PH_MUTE = 2'd3
  } phase_t;

  typedef struct packed {
    in_kind_t   item_kind;
    logic [7:0] raw_byte;
  } in_word_t;

  typedef struct packed {
    res_kind_t  result_kind;
    logic [7:0] data_byte;
  } out_word_t;

  // hex digit value, unchecked, mod 256
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= CHAR_UPA) begin
      v = (c & CASE_MASK) - CHAR_UPA + LETTER_OFS;
    end else begin
      v = c - CHAR_ZERO;
    end
    return v;
  endfunction

endpackage

[rtl/query_string_field_decoder.sv]
`timescale 1ns / 1ps
// query_string_field_decoder: percent decoding and field splitting of a
// query string, one word per cycle when not stalled; depends on qsfd_pkg
//
// Usage:
//   in channel  (in_valid, in_stall, in_word): one raw query byte per word,
//     or an end-of-string word (item_kind = IK_END).
//   out channel (out_valid, out_stall, out_word): decoded data bytes and one
//     end-of-field word after every field that held raw bytes.
//   Each input word gives zero or one output word.
//   A word accepted into the input register is decoded into the output
//   register as soon as that register can advance, and then shows on out_word.
//   Throughput: one word per cycle when not stalled; the decode step is a
//   single pass of small logic between the input and output registers.
//   When the receiver stalls, the output register holds its word and the
//   input register holds one more word; in_stall rises only when both are
//   full and out_stall is high.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   decoder to plain copying with no open field.

module query_string_field_decoder
  import qsfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic       in_valid_r;
  in_word_t   in_word_r;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_word_r, out_word_nxt;
  phase_t     phase_r, phase_nxt;
  logic [7:0] high_r, high_nxt;
  logic       has_raw_r, has_raw_nxt;

  logic       advance;
  logic       proc;
  logic       is_end;
  logic [7:0] chr;
  logic [7:0] esc_val;
  logic       emit;
  logic [7:0] emit_byte;

  assign advance  = !(out_valid_r && out_stall);
  assign proc     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_word_r <= in_word;
    end
  end

  always_comb begin
    is_end    = (in_word_r.item_kind == IK_END) || (in_word_r.raw_byte == CHAR_AMP) ||
                (in_word_r.raw_byte == CHAR_SEMI);
    chr       = (in_word_r.raw_byte == CHAR_PLUS) ? CHAR_SPACE : in_word_r.raw_byte;
    esc_val   = {high_r[3:0], 4'b0000} + digit_value(chr);
    phase_nxt = phase_r;
    high_nxt  = high_r;
    has_raw_nxt = has_raw_r;
    emit      = 1'b0;
    emit_byte = chr;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;

    if (proc) begin
      if (is_end) begin
        phase_nxt   = PH_COPY;
        high_nxt    = '0;
        has_raw_nxt = 1'b0;
      end else begin
        has_raw_nxt = 1'b1;
        case (phase_r)
          PH_COPY: begin
            if (chr == CHAR_PCT) begin
              phase_nxt = PH_PCT;
            end else begin
              emit      = 1'b1;
              emit_byte = chr;
            end
          end
          PH_PCT: begin
            high_nxt  = digit_value(chr);
            phase_nxt = PH_HIGH;
          end
          PH_HIGH: begin
            high_nxt  = '0;
            phase_nxt = PH_COPY;
            emit      = 1'b1;
            emit_byte = esc_val;
          end
          default: begin
          end
        endcase
        // decoded zero byte mutes the rest of the field
        if (emit && emit_byte == 8'h00) begin
          emit      = 1'b0;
          phase_nxt = PH_MUTE;
        end
      end

      if (is_end) begin
        out_valid_nxt = has_raw_r;
        out_word_nxt.result_kind = RK_END;
        out_word_nxt.data_byte   = '0;
      end else begin
        out_valid_nxt = emit;
        out_word_nxt.result_kind = RK_DATA;
        out_word_nxt.data_byte   = emit_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= PH_COPY;
      high_r      <= '0;
      has_raw_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      high_r      <= high_nxt;
      has_raw_r   <= has_raw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.result_kind == RK_END |-> out_word_r.data_byte == 8'h00)
    else $error("end-of-field word carries nonzero data");

  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.result_kind == RK_DATA |-> out_word_r.data_byte != 8'h00)
    else $error("decoded zero byte emitted");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    proc && is_end |=> phase_r == PH_COPY && !has_raw_r && high_r == 8'h00)
    else $error("field end did not clear decoder state");

  a_escape_open: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_COPY |-> has_raw_r)
    else $error("escape phase active with no open field");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_valid_r && $stable(phase_r) && $stable(has_raw_r))
    else $error("decoder advanced while output blocked");

endmodule

[tb/query_string_field_decoder_test.sv]
`timescale 1ns / 1ps
// query_string_field_decoder_test: self-checking bench for the query string field decoder;
// a queue-fed driver, a random-stall receiver and an in-bench decoder model check every word
// depends on qsfd_pkg and query_string_field_decoder

module query_string_field_decoder_test;
  import qsfd_pkg::*;

  localparam int RANDOM_WORDS = 1920;
  localparam int QUIET_LIMIT  = 3000;
  localparam int MAX_WAIT     = 16;

  typedef struct packed {
    in_word_t word;
    logic     drain;
  } send_item_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  send_item_t send_q[$];
  out_word_t  decoded_q[$];

  // decoder model state
  phase_t     esc_phase = PH_COPY;
  logic [7:0] hi_digit = 8'h00;
  bit         field_open = 1'b0;

  bit in_fire = 1'b0;
  bit out_fire = 1'b0;
  int quiet = 0;
  int errors = 0;
  int words_fed = 0;
  int data_seen = 0;
  int ends_seen = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;

  query_string_field_decoder dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [7:0] escape_digit(input logic [7:0] c);
    logic [7:0] folded;
    folded = {c[7:6], 1'b0, c[4:0]};
    if (c >= CHAR_UPA) begin
      return folded - 8'd55;
    end
    return c - 8'd48;
  endfunction

  // advances the model by one word; returns 1 when a result word comes out
  function automatic bit decode_word(input in_word_t w, output out_word_t r);
    logic [7:0] c;
    logic [7:0] v;
    bit emit;
    c = w.raw_byte;
    v = 8'h00;
    emit = 1'b0;
    r.result_kind = RK_DATA;
    r.data_byte = 8'h00;
    if (w.item_kind == IK_END || c == CHAR_AMP || c == CHAR_SEMI) begin
      emit = field_open;
      r.result_kind = RK_END;
      esc_phase = PH_COPY;
      hi_digit = 8'h00;
      field_open = 1'b0;
      return emit;
    end
    field_open = 1'b1;
    if (c == CHAR_PLUS) begin
      c = CHAR_SPACE;
    end
    case (esc_phase)
      PH_COPY: begin
        if (c == CHAR_PCT) begin
          esc_phase = PH_PCT;
        end else begin
          v = c;
          emit = 1'b1;
        end
      end
      PH_PCT: begin
        hi_digit = escape_digit(c);
        esc_phase = PH_HIGH;
      end
      PH_HIGH: begin
        v = {hi_digit[3:0], 4'h0} + escape_digit(c);
        hi_digit = 8'h00;
        esc_phase = PH_COPY;
        emit = 1'b1;
      end
      default: begin
      end
    endcase
    // a decoded zero silences the rest of the field
    if (emit && v == 8'h00) begin
      esc_phase = PH_MUTE;
      emit = 1'b0;
    end
    r.data_byte = v;
    return emit;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) begin
      return CHAR_ZERO + {4'h0, n};
    end
    return (lower ? 8'h61 : CHAR_UPA) + {4'h0, n} - 8'd10;
  endfunction

  task automatic push_word(input in_kind_t kind, input logic [7:0] b, input bit drain);
    send_item_t s;
    s.word.item_kind = kind;
    s.word.raw_byte = b;
    s.drain = drain;
    send_q.push_back(s);
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_word(IK_BYTE, b, 1'b0);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i]);
    end
  endtask

  task automatic push_hex_escape();
    push_byte(CHAR_PCT);
    push_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
    push_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
  endtask

  // result check and model update at the rising edge
  always @(posedge clk) begin : monitor
    out_word_t want;
    if (rst_n) begin
      out_fire = out_valid && !out_stall;
      in_fire = in_valid && !in_stall;
      if (out_fire) begin
        if (decoded_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word kind %0d byte %02h", $time,
                   out_word.result_kind, out_word.data_byte);
        end else begin
          want = decoded_q.pop_front();
          if (want.result_kind != out_word.result_kind) begin
            errors++;
            $display("%0t: result_kind expected %0d got %0d", $time,
                     want.result_kind, out_word.result_kind);
          end
          if (want.data_byte != out_word.data_byte) begin
            errors++;
            $display("%0t: data_byte expected %02h got %02h", $time,
                     want.data_byte, out_word.data_byte);
          end
          if (want.result_kind == RK_END) begin
            ends_seen++;
          end else begin
            data_seen++;
          end
        end
      end
      if (in_fire) begin
        words_fed++;
        if (decode_word(in_word, want)) begin
          decoded_q.push_back(want);
        end
      end
      if (in_fire || out_fire) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
  end

  // sender, changes at the falling edge
  always @(negedge clk) begin : driver
    logic       next_valid;
    in_word_t   next_word;
    send_item_t s;
    next_valid = in_valid;
    next_word = in_word;
    if (rst_n) begin
      if (in_fire) begin
        next_valid = 1'b0;
        if ($urandom_range(0, 99) == 0) begin
          send_calm = !send_calm;
        end
        gap_left = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (send_q.size() > 0) begin
          if (!send_q[0].drain || decoded_q.size() == 0) begin
            s = send_q.pop_front();
            next_word = s.word;
            next_valid = 1'b1;
          end
        end
      end
    end
    in_valid <= next_valid;
    in_word <= next_word;
  end

  // receiver stall, redrawn after every accepted result word
  always @(negedge clk) begin : receiver
    if (rst_n) begin
      if (out_fire) begin
        if ($urandom_range(0, 99) == 0) begin
          recv_calm = !recv_calm;
        end
        stall_left = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk);
    end
    $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : main
    int r;
    int n;
    logic [7:0] b;
    bit hold;

    // directed: plain copy, escapes, separators, plus handling, mute and cut-short cases
    push_text("a%41&");
    push_text("&+%2b%00q;");
    push_byte(8'hFF);
    push_byte(CHAR_PCT);
    push_byte(8'h80);
    push_byte(8'hC1);
    push_text("%+1");
    push_byte(8'h00);
    push_text("z;");
    push_text("%4");
    push_word(IK_END, 8'hFF, 1'b0);
    push_word(IK_END, 8'h00, 1'b0);

    // random: mostly well-formed fields with random content, some noise
    hold = 1'b1;
    while (send_q.size() < RANDOM_WORDS + 29) begin
      if (hold) begin
        push_word(IK_BYTE, 8'($urandom_range(1, 255)), 1'b1);
        hold = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (r < 40) begin
        b = CHAR_PCT;
        while (b == CHAR_PCT || b == CHAR_AMP || b == CHAR_SEMI) begin
          b = 8'($urandom_range(1, 255));
        end
        push_byte(b);
      end else if (r < 50) begin
        push_byte(CHAR_PLUS);
      end else if (r < 75) begin
        push_hex_escape();
      end else if (r < 80) begin
        push_byte(CHAR_PCT);
        push_byte(8'($urandom_range(1, 255)));
        push_byte(8'($urandom_range(1, 255)));
      end else if (r < 90) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          push_byte($urandom_range(0, 1) ? CHAR_AMP : CHAR_SEMI);
        end
      end else if (r < 94) begin
        push_word(IK_END, 8'($urandom_range(0, 255)), 1'b0);
      end else if (r < 98) begin
        push_byte(CHAR_PCT);
        if ($urandom_range(0, 1)) begin
          push_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
        end
        if ($urandom_range(0, 1)) begin
          push_byte($urandom_range(0, 1) ? CHAR_AMP : CHAR_SEMI);
        end else begin
          push_word(IK_END, 8'($urandom_range(0, 255)), 1'b0);
        end
      end else begin
        push_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 299) == 0) begin
        hold = 1'b1;
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (send_q.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (decoded_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (10) @(posedge clk);

    $display("fed %0d words; checked %0d data bytes and %0d field ends, %0d mismatches",
             words_fed, data_seen, ends_seen, errors);
    if (errors == 0 && decoded_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/qsfd_pkg.sv
rtl/query_string_field_decoder.sv
tb/query_string_field_decoder_test.sv
